[rtl/core/bt_net_pkg.sv]
// Shared constants, types and helpers for the binary threshold net evaluator.
`timescale 1ns / 1ps

package bt_net_pkg;

  // Network shape.
  localparam int NUM_INPUTS  = 25;
  localparam int NUM_HIDDEN  = 10;
  localparam int NUM_OUTPUTS = 4;

  // Weight store layout: input-major input-to-hidden block, then hidden-major
  // hidden-to-output block.
  localparam int IH_COUNT     = NUM_INPUTS * NUM_HIDDEN;
  localparam int WEIGHT_DEPTH = IH_COUNT + NUM_HIDDEN * NUM_OUTPUTS;
  localparam int ADDR_W       = $clog2(WEIGHT_DEPTH);

  // Fixed field widths of the ports.
  localparam int GENE_W    = 7;
  localparam int INDEX_W   = 9;
  localparam int SENSE_W   = 25;
  localparam int CHOICE_W  = 4;
  localparam int SENSE_IW  = $clog2(SENSE_W);
  localparam int CHOICE_IW = $clog2(CHOICE_W);

  // Weight encoding.
  localparam int WEIGHT_W    = 8;
  localparam int GENE_OFFSET = 82;

  // Counter width covers every loop bound and every field index.
  localparam int MAX_A   = (NUM_INPUTS > NUM_HIDDEN) ? NUM_INPUTS : NUM_HIDDEN;
  localparam int MAX_B   = (MAX_A > NUM_OUTPUTS) ? MAX_A : NUM_OUTPUTS;
  localparam int MAX_FAN = (MAX_B > SENSE_W) ? MAX_B : SENSE_W;
  localparam int CNT_W   = $clog2(MAX_FAN);
  localparam int HID_IW  = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1;

  // Accumulator holds a sum of up to MAX_A signed weights exactly.
  localparam int ACC_W = WEIGHT_W + $clog2(MAX_A + 1);

  // Operation codes of an input beat.
  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              wr_en;
    logic              start;
    logic              rd_en;
    logic              phase_out;
    logic              last;
    logic [CNT_W-1:0]  unit;
    logic [CNT_W-1:0]  inner;
    logic [ADDR_W-1:0] addr;
    logic              load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } status_t;

  // A genome character becomes a signed weight: code minus the offset.
  function automatic logic [WEIGHT_W-1:0] gene_to_weight(input logic [GENE_W-1:0] code);
    logic [WEIGHT_W-1:0] ext;
    ext = WEIGHT_W'(code);
    return ext - WEIGHT_W'(GENE_OFFSET);
  endfunction

endpackage

[rtl/core/binary_threshold_net_eval.sv]
// Top level of the binary threshold net evaluator.
`timescale 1ns / 1ps
//
//  Channel  Direction  Handshake               Beat fields
//  in       input      in_valid_i / in_stall_o  operation_i, weight_index_i,
//                                               gene_char_i, sense_bits_i
//  out      output     out_valid_o / out_stall_i choice_bits_o
//
// A write beat produces no result.
// An evaluate beat is sequenced by the one shared accumulator, which reads
// each stored weight once through the single read port of the memory.
// Reset clears control state only; the weight memory is undefined until written.
// A result waits in its output register under out_stall_i while the next beat
// is accepted; an evaluate finishing behind a held result waits for it.

module binary_threshold_net_eval (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             operation_i,
  input  logic [bt_net_pkg::INDEX_W-1:0]   weight_index_i,
  input  logic [bt_net_pkg::GENE_W-1:0]    gene_char_i,
  input  logic [bt_net_pkg::SENSE_W-1:0]   sense_bits_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [bt_net_pkg::CHOICE_W-1:0]  choice_bits_o
);

  bt_net_pkg::cmd_t    cmd;
  bt_net_pkg::status_t status;

  // Controller.
  bt_net_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath.
  bt_net_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .weight_index_i (weight_index_i),
    .gene_char_i    (gene_char_i),
    .sense_bits_i   (sense_bits_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .choice_bits_o  (choice_bits_o)
  );

endmodule

[rtl/core/bt_net_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bt_net_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/bt_net_ctrl.sv]
// Controller state machine: accepts beats and sequences the weight walk.
`timescale 1ns / 1ps

module bt_net_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 operation_i,
  input  bt_net_pkg::status_t  status_i,
  output bt_net_pkg::cmd_t     cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_HID   = 5'b00010,
    S_OUT   = 5'b00100,
    S_DRAIN = 5'b01000,
    S_FIN   = 5'b10000
  } state_e;

  state_e                          state_q, state_d;
  logic [bt_net_pkg::CNT_W-1:0]    inner_q, inner_d;
  logic [bt_net_pkg::CNT_W-1:0]    outer_q, outer_d;
  logic [bt_net_pkg::ADDR_W-1:0]   addr_q, addr_d;

  // Next-state and command logic.
  always_comb begin
    state_d       = state_q;
    inner_d       = inner_q;
    outer_d       = outer_q;
    addr_d        = addr_q;
    cmd_o         = '0;
    cmd_o.addr    = addr_q;
    cmd_o.unit    = outer_q;
    cmd_o.inner   = inner_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (bt_net_pkg::op_e'(operation_i) == bt_net_pkg::OP_WRITE) begin
            cmd_o.wr_en = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            inner_d     = '0;
            outer_d     = '0;
            addr_d      = '0;
            state_d     = S_HID;
          end
        end
      end
      S_HID: begin
        // Inner loop runs over inputs, outer over hidden units.
        cmd_o.rd_en = 1'b1;
        cmd_o.last  = (inner_q == bt_net_pkg::CNT_W'(bt_net_pkg::NUM_INPUTS - 1));
        if (cmd_o.last) begin
          inner_d = '0;
          if (outer_q == bt_net_pkg::CNT_W'(bt_net_pkg::NUM_HIDDEN - 1)) begin
            outer_d = '0;
            addr_d  = bt_net_pkg::ADDR_W'(bt_net_pkg::IH_COUNT);
            state_d = S_OUT;
          end else begin
            outer_d = outer_q + bt_net_pkg::CNT_W'(1);
            addr_d  = bt_net_pkg::ADDR_W'(outer_q) + bt_net_pkg::ADDR_W'(1);
          end
        end else begin
          inner_d = inner_q + bt_net_pkg::CNT_W'(1);
          addr_d  = addr_q + bt_net_pkg::ADDR_W'(bt_net_pkg::NUM_HIDDEN);
        end
      end
      S_OUT: begin
        // Inner loop runs over hidden units, outer over output units.
        cmd_o.rd_en     = 1'b1;
        cmd_o.phase_out = 1'b1;
        cmd_o.last      = (inner_q == bt_net_pkg::CNT_W'(bt_net_pkg::NUM_HIDDEN - 1));
        if (cmd_o.last) begin
          inner_d = '0;
          if (outer_q == bt_net_pkg::CNT_W'(bt_net_pkg::NUM_OUTPUTS - 1)) begin
            outer_d = '0;
            state_d = S_DRAIN;
          end else begin
            outer_d = outer_q + bt_net_pkg::CNT_W'(1);
            addr_d  = bt_net_pkg::ADDR_W'(bt_net_pkg::IH_COUNT)
                    + bt_net_pkg::ADDR_W'(outer_q) + bt_net_pkg::ADDR_W'(1);
          end
        end else begin
          inner_d = inner_q + bt_net_pkg::CNT_W'(1);
          addr_d  = addr_q + bt_net_pkg::ADDR_W'(bt_net_pkg::NUM_OUTPUTS);
        end
      end
      S_DRAIN: begin
        // The last read is summed in this cycle.
        state_d = S_FIN;
      end
      S_FIN: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  // State and counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      inner_q <= '0;
      outer_q <= '0;
      addr_q  <= '0;
    end else begin
      state_q <= state_d;
      inner_q <= inner_d;
      outer_q <= outer_d;
      addr_q  <= addr_d;
    end
  end

  // Hidden-layer reads stay inside the input-to-hidden block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.rd_en && !cmd_o.phase_out) |-> (32'(cmd_o.addr) < bt_net_pkg::IH_COUNT))
    else $error("hidden-layer read outside input-to-hidden weights");

  // Output-layer reads stay inside the hidden-to-output block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.rd_en && cmd_o.phase_out) |->
      ((32'(cmd_o.addr) >= bt_net_pkg::IH_COUNT) &&
       (32'(cmd_o.addr) < bt_net_pkg::WEIGHT_DEPTH)))
    else $error("output-layer read outside hidden-to-output weights");

  // An evaluation never starts in the same cycle as a weight write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.start && cmd_o.wr_en))
    else $error("start and write issued together");

endmodule

[rtl/core/bt_net_dp.sv]
// Datapath: weight memory, shared accumulator, hidden bits and result register.
`timescale 1ns / 1ps

module bt_net_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bt_net_pkg::cmd_t                  cmd_i,
  output bt_net_pkg::status_t               status_o,
  input  logic [bt_net_pkg::INDEX_W-1:0]    weight_index_i,
  input  logic [bt_net_pkg::GENE_W-1:0]     gene_char_i,
  input  logic [bt_net_pkg::SENSE_W-1:0]    sense_bits_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [bt_net_pkg::CHOICE_W-1:0]   choice_bits_o
);

  localparam int AW = bt_net_pkg::ADDR_W;
  localparam int WW = bt_net_pkg::WEIGHT_W;
  localparam int AC = bt_net_pkg::ACC_W;

  logic                               we;
  logic [WW-1:0]                      rdata;

  // Read-stage tags are registered alongside the RAM read.
  logic                               rd_vld_q;
  logic                               phase_q;
  logic                               last_q;
  logic [bt_net_pkg::CNT_W-1:0]       unit_q;
  logic [bt_net_pkg::CNT_W-1:0]       inner_q;

  logic [bt_net_pkg::SENSE_W-1:0]     sense_q, sense_d;
  logic [AC-1:0]                      acc_q, acc_d;
  logic [bt_net_pkg::NUM_HIDDEN-1:0]  hid_q, hid_d;
  logic [bt_net_pkg::CHOICE_W-1:0]    choice_q, choice_d;
  logic [bt_net_pkg::CHOICE_W-1:0]    choice_out_q, choice_out_d;
  logic                               out_valid_q, out_valid_d;

  logic                               term_en;
  logic [AC-1:0]                      term;
  logic [AC-1:0]                      sum;
  logic                               positive;

  // Writes beyond the store are dropped.
  assign we = cmd_i.wr_en &&
              (32'(weight_index_i) < bt_net_pkg::WEIGHT_DEPTH);

  bt_net_ram #(
    .WIDTH (WW),
    .DEPTH (bt_net_pkg::WEIGHT_DEPTH)
  ) u_weights (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (AW'(weight_index_i)),
    .wdata_i (bt_net_pkg::gene_to_weight(gene_char_i)),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.addr),
    .rdata_o (rdata)
  );

  // Term select: a sense bit gates hidden sums, a hidden bit gates output sums.
  always_comb begin
    if (phase_q) begin
      term_en = hid_q[inner_q[bt_net_pkg::HID_IW-1:0]];
    end else begin
      term_en = (32'(inner_q) < bt_net_pkg::SENSE_W) &&
                sense_q[inner_q[bt_net_pkg::SENSE_IW-1:0]];
    end
    term     = term_en ? {{(AC - WW){rdata[WW-1]}}, rdata} : '0;
    sum      = acc_q + term;
    positive = !sum[AC-1] && (sum != '0);
  end

  // Accumulate, and at the end of each group record the step decision.
  always_comb begin
    sense_d      = sense_q;
    acc_d        = acc_q;
    hid_d        = hid_q;
    choice_d     = choice_q;
    choice_out_d = choice_out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    if (cmd_i.start) begin
      sense_d  = sense_bits_i;
      acc_d    = '0;
      choice_d = '0;
    end
    if (rd_vld_q) begin
      acc_d = last_q ? '0 : sum;
      if (last_q && !phase_q) begin
        hid_d[unit_q[bt_net_pkg::HID_IW-1:0]] = positive;
      end
      if (last_q && phase_q && (32'(unit_q) < bt_net_pkg::CHOICE_W)) begin
        choice_d[unit_q[bt_net_pkg::CHOICE_IW-1:0]] = positive;
      end
    end
    if (cmd_i.load_out) begin
      choice_out_d = choice_q;
      out_valid_d  = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q    <= cmd_i.rd_en;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    phase_q      <= cmd_i.phase_out;
    last_q       <= cmd_i.last;
    unit_q       <= cmd_i.unit;
    inner_q      <= cmd_i.inner;
    sense_q      <= sense_d;
    acc_q        <= acc_d;
    hid_q        <= hid_d;
    choice_q     <= choice_d;
    choice_out_q <= choice_out_d;
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign choice_bits_o     = choice_out_q;

  // The result register is loaded only when it is empty or being taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten while held");

  // No weight write lands while a read is still in the pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en |-> !rd_vld_q)
    else $error("weight write during evaluation");

endmodule
